[hdl/swfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_pkg
// Shared types, constants and the CRC-8 helper for the sensor word deframer.
// ----------------------------------------------------------------------------
package swfd_pkg;

  localparam logic [7:0]  CRC_POLY   = 8'h31;
  localparam logic [7:0]  CRC_INIT   = 8'hFF;
  localparam logic [10:0] READY_MASK = 11'h7FF;

  localparam logic [1:0] POS_HIGH = 2'd0;
  localparam logic [1:0] POS_LOW  = 2'd1;
  localparam logic [1:0] POS_CRC  = 2'd2;

  localparam logic [1:0] IDX_CO2  = 2'd0;
  localparam logic [1:0] IDX_TEMP = 2'd1;

  localparam logic       KIND_STATUS = 1'b0;
  localparam logic       KIND_MEAS   = 1'b1;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] HUM_SCALE   = 15'd10000;
  localparam logic [16:0] TEMP_OFFSET = 17'd4500;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  localparam int DATA_W = 40;

  typedef struct packed {
    logic [1:0]  word_index;
    logic [15:0] raw_word;
    logic        crc_ok;
    logic        frame_good;
    logic        last;
    logic        kind;
  } word_evt_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hdl/swfd_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_framer
// Byte triplet framing, running CRC-8 check and frame status; registers one
// completed word per CRC byte.
// ----------------------------------------------------------------------------
module swfd_framer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  input  logic                response_kind,
  output swfd_pkg::word_evt_t evt,
  output logic                evt_valid,
  input  logic                evt_ready
);
  import swfd_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  logic [1:0] wcnt_r, wcnt_nxt;
  logic [7:0] high_r, high_nxt;
  logic [7:0] low_r, low_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       fok_r, fok_nxt;
  word_evt_t  evt_r, evt_nxt;
  logic       evt_valid_r, evt_valid_nxt;

  logic [1:0] pos_eff, wcnt_eff, final_idx;
  logic [7:0] crc_eff;
  logic       fok_eff, ok, good, last, accept, emit, drain;

  assign drain    = evt_valid_r && evt_ready;
  assign in_ready = !evt_valid_r || evt_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pos_eff   = frame_start ? POS_HIGH : pos_r;
    wcnt_eff  = frame_start ? 2'd0 : wcnt_r;
    crc_eff   = frame_start ? CRC_INIT : crc_r;
    fok_eff   = frame_start ? 1'b1 : fok_r;
    final_idx = (response_kind == KIND_MEAS) ? 2'd2 : 2'd0;
    ok        = (crc_eff == rx_byte);
    good      = fok_eff && ok;
    last      = (wcnt_eff >= final_idx);

    pos_nxt  = pos_r;
    wcnt_nxt = wcnt_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    crc_nxt  = crc_r;
    fok_nxt  = fok_r;
    emit     = 1'b0;

    evt_nxt            = evt_r;
    evt_nxt.word_index = wcnt_eff;
    evt_nxt.raw_word   = {high_r, low_r};
    evt_nxt.crc_ok     = ok;
    evt_nxt.frame_good = good;
    evt_nxt.last       = last;
    evt_nxt.kind       = response_kind;

    if (accept) begin
      wcnt_nxt = wcnt_eff;
      fok_nxt  = fok_eff;
      if (pos_eff == POS_LOW) begin
        low_nxt = rx_byte;
        crc_nxt = crc_feed(crc_eff, rx_byte);
        pos_nxt = POS_CRC;
      end else if (pos_eff != POS_CRC) begin
        high_nxt = rx_byte;
        crc_nxt  = crc_feed(CRC_INIT, rx_byte);
        pos_nxt  = POS_LOW;
      end else begin
        emit    = 1'b1;
        pos_nxt = POS_HIGH;
        crc_nxt = CRC_INIT;
        if (last) begin
          wcnt_nxt = 2'd0;
          fok_nxt  = 1'b1;
        end else begin
          wcnt_nxt = wcnt_eff + 2'd1;
          fok_nxt  = good;
        end
      end
    end

    if (emit) begin
      evt_valid_nxt = 1'b1;
    end else if (drain) begin
      evt_valid_nxt = 1'b0;
    end else begin
      evt_valid_nxt = evt_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HIGH;
      wcnt_r      <= 2'd0;
      high_r      <= 8'd0;
      low_r       <= 8'd0;
      crc_r       <= CRC_INIT;
      fok_r       <= 1'b1;
      evt_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      wcnt_r      <= wcnt_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      crc_r       <= crc_nxt;
      fok_r       <= fok_nxt;
      evt_valid_r <= evt_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      evt_r <= evt_nxt;
    end
  end

  assign evt       = evt_r;
  assign evt_valid = evt_valid_r;

endmodule

[hdl/swfd_convert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_convert
// Converts a completed word to its physical value (CO2 word passed raw, status
// words give a ready flag) and holds the result word in the output register.
// ----------------------------------------------------------------------------
module swfd_convert (
  input  logic                      clk,
  input  logic                      rst_n,
  input  swfd_pkg::word_evt_t       evt,
  input  logic                      evt_valid,
  output logic                      evt_ready,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [swfd_pkg::DATA_W-1:0] out_tdata,
  output logic [1:0]                out_tuser,
  output logic                      out_tlast
);
  import swfd_pkg::*;

  logic [DATA_W-1:0] data_r, data_nxt;
  logic [1:0]        user_r;
  logic              last_r;
  logic              valid_r, valid_nxt;

  logic [14:0] scale;
  logic [30:0] prod;
  logic [16:0] part_sum;
  logic [14:0] quot;
  logic [16:0] conv;
  logic        ready_flag, load;

  assign evt_ready = !valid_r || out_tready;
  assign load      = evt_valid && evt_ready;

  // prod / 65535 = q0 + carry, where prod = 65536*q0 + r0 and carry = (q0 + r0 >= 65535)
  always_comb begin
    scale      = (evt.word_index == IDX_TEMP) ? TEMP_SCALE : HUM_SCALE;
    prod       = scale * evt.raw_word;
    part_sum   = {2'b00, prod[30:16]} + {1'b0, prod[15:0]};
    quot       = prod[30:16] + {14'd0, (part_sum >= FULL_SCALE)};
    ready_flag = (evt.raw_word[10:0] & READY_MASK) != 11'd0;

    if (evt.kind == KIND_STATUS) begin
      conv = {16'd0, ready_flag};
    end else begin
      case (evt.word_index)
        IDX_CO2:  conv = {1'b0, evt.raw_word};
        IDX_TEMP: conv = {2'b00, quot} - TEMP_OFFSET;
        default:  conv = {2'b00, quot};
      endcase
    end

    data_nxt = {4'd0, evt.frame_good, (evt.kind == KIND_STATUS) && ready_flag,
                conv, evt.crc_ok, evt.raw_word};

    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      user_r <= evt.word_index;
      last_r <= evt.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

[hdl/sensor_word_frame_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_word_frame_decoder_core
// CRC-8 checked word deframer for sensor response bytes.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_tready is high; one result word per three bytes.
// Path: the result is registered in the framer word register, then in the
//   conversion/output register, after the CRC byte is accepted.
// Input keeps flowing while one result waits; a second stalled word blocks.
// Reset: synchronous active-low; clears framing, CRC and flags, kind = 1.
// ----------------------------------------------------------------------------
module sensor_word_frame_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] raw_word, [16] crc_ok, [33:17] converted_value,
                                  // [34] data_ready, [35] frame_good, [39:36] zero
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);
  import swfd_pkg::*;

  logic      kind_r;
  word_evt_t evt;
  logic      evt_valid, evt_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_MEAS;
    end else if (cfg_wr_en) begin
      kind_r <= cfg_wr_data;
    end
  end

  swfd_framer u_framer (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .rx_byte       (in_tdata),
    .frame_start   (in_tuser[0]),
    .response_kind (kind_r),
    .evt           (evt),
    .evt_valid     (evt_valid),
    .evt_ready     (evt_ready)
  );

  swfd_convert u_convert (
    .clk        (clk),
    .rst_n      (rst_n),
    .evt        (evt),
    .evt_valid  (evt_valid),
    .evt_ready  (evt_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[hdl/swfd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_checker
// Port-level checks for the sensor word deframer, bound to the top level.
// ----------------------------------------------------------------------------
module swfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("word index out of range");

  a_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[16] |-> !out_tdata[35])
    else $error("frame good despite CRC mismatch");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind sensor_word_frame_decoder_core swfd_checker u_swfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
